FILE: design/b64d_pkg.sv
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_CHAR   = 2'd1,
    STATUS_BAD_LENGTH = 2'd2
  } status_t;

  // Results caused by one character: 'count' words, either bytes of 'bytes'
  // (top byte first) or a single marker word carrying 'status'.
  typedef struct packed {
    logic [1:0]  count;
    logic [23:0] bytes;
    logic        is_data;
    logic        eom;
    status_t     status;
  } bundle_t;

  // {bad, sextet}; bad set for anything outside the standard alphabet.
  function automatic logic [6:0] map_char(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c inside {[8'h41:8'h5A]}) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b0, 6'd63};
    end
    return r;
  endfunction

endpackage

FILE: design/base64_decoder_unit.sv
// Base64 decoder, standard alphabet.
// Slave channel: one character per word on s_tdata, s_tlast on the final
// character of a message. Master channel: one result per word; m_tdata is
// the decoded byte, m_tuser[0] says it is a byte, m_tuser[2:1] carries the
// status (ok, bad character, bad length), m_tlast closes the message.
// A full group of four characters gives up to three byte words; '=' pads
// cut that to two, one or none. Errors give a single marker word, then the
// rest of the message is dropped up to its last character, which yields a
// bare end marker. Bytes already sent stay sent.
// A result word passes through the input register, then the result
// register of the serializer, before it is presented on the master side.
// Throughput: one character per cycle sustained on well-formed input
// while the receiver is ready. The serializer drains one word per cycle
// then; a three-byte group holds it for three words, which the three
// following characters of the next group cover. A character that needs
// the serializer while it is still busy waits in the input register, and
// the slave side stalls only then.
// Reset (rst, synchronous) clears group, error skip and both stages. A
// receiver stall holds the word; decoding goes on until the input blocks.
module base64_decoder_unit
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  input  logic       s_tlast,   // last_char
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] data_byte
  output logic [2:0] m_tuser,   // [0] byte_valid, [2:1] status
  output logic       m_tlast    // end_of_message
);

  logic    bundle_valid;
  bundle_t bundle;
  logic    load_ok;

  // character register, alphabet map, group accumulator
  b64d_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .load_ok      (load_ok),
    .bundle_valid (bundle_valid),
    .bundle       (bundle)
  );

  // result register, one word per cycle while the receiver is ready
  b64d_serial u_serial (
    .clk          (clk),
    .rst          (rst),
    .bundle_valid (bundle_valid),
    .bundle       (bundle),
    .load_ok      (load_ok),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast)
  );

endmodule

FILE: design/b64d_decode.sv
module b64d_decode
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  input  logic       s_tlast,   // last_char
  input  logic       load_ok,
  output logic       bundle_valid,
  output bundle_t    bundle
);

  logic        a_valid;
  logic [7:0]  a_char;
  logic        a_last;

  logic [17:0] acc, acc_next;
  logic [1:0]  pos, pos_next;
  logic [2:0]  pad, pad_next;
  logic        skip, skip_next;

  logic        has_result;
  logic        advance;
  logic        s_fire;
  logic [6:0]  mapped;
  logic        is_pad;
  logic [2:0]  pad_inc;
  logic [5:0]  sextet;
  logic [23:0] val;
  bundle_t     bnd;

  assign mapped  = map_char(a_char);
  assign is_pad  = (a_char == PAD_CHAR);
  assign pad_inc = is_pad ? pad + 3'd1 : pad;
  assign sextet  = is_pad ? 6'd0 : mapped[5:0];
  assign val     = {acc, sextet};

  always_comb begin
    acc_next   = acc;
    pos_next   = pos;
    pad_next   = pad;
    skip_next  = skip;
    has_result = 1'b0;
    bnd        = '{count: 2'd1, bytes: 24'd0, is_data: 1'b0, eom: 1'b0,
                   status: STATUS_OK};
    if (skip) begin
      if (a_last) begin
        skip_next  = 1'b0;
        acc_next   = '0;
        pos_next   = '0;
        pad_next   = '0;
        has_result = 1'b1;
        bnd.eom    = 1'b1;
      end
    end else if (!is_pad && mapped[6]) begin
      acc_next   = '0;
      pos_next   = '0;
      pad_next   = '0;
      skip_next  = !a_last;
      has_result = 1'b1;
      bnd.eom    = a_last;
      bnd.status = STATUS_BAD_CHAR;
    end else if (pos != 2'd3) begin
      acc_next = val[17:0];
      pos_next = pos + 2'd1;
      pad_next = pad_inc;
      if (a_last) begin
        // group cut short by end of message
        acc_next   = '0;
        pos_next   = '0;
        pad_next   = '0;
        has_result = 1'b1;
        bnd.eom    = 1'b1;
        bnd.status = STATUS_BAD_LENGTH;
      end
    end else begin
      acc_next  = '0;
      pos_next  = '0;
      pad_next  = '0;
      bnd.bytes = val;
      bnd.eom   = a_last;
      case (pad_inc)
        3'd0:    bnd.count = 2'd3;
        3'd1:    bnd.count = 2'd2;
        3'd2:    bnd.count = 2'd1;
        default: bnd.count = 2'd0;
      endcase
      if (bnd.count != 2'd0) begin
        has_result  = 1'b1;
        bnd.is_data = 1'b1;
      end else if (a_last) begin
        // group of three or four pads closing the message: bare end marker
        has_result = 1'b1;
        bnd.count  = 2'd1;
        bnd.bytes  = '0;
      end
    end
  end

  assign advance      = a_valid && (!has_result || load_ok);
  assign s_tready     = !a_valid || advance;
  assign s_fire       = s_tvalid && s_tready;
  assign bundle_valid = a_valid && has_result;
  assign bundle       = bnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      acc     <= '0;
      pos     <= '0;
      pad     <= '0;
      skip    <= 1'b0;
    end else begin
      if (s_fire) begin
        a_valid <= 1'b1;
      end else if (advance) begin
        a_valid <= 1'b0;
      end
      if (advance) begin
        acc  <= acc_next;
        pos  <= pos_next;
        pad  <= pad_next;
        skip <= skip_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      a_char <= s_tdata;
      a_last <= s_tlast;
    end
  end

  a_pad_range: assert property (@(posedge clk) disable iff (rst)
    pad <= 3'd4)
    else $error("pad count beyond a full group");

  a_skip_clear: assert property (@(posedge clk) disable iff (rst)
    skip |-> (pos == 2'd0 && pad == 3'd0))
    else $error("group not cleared while skipping");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !advance) |=> (a_valid && $stable(a_char) && $stable(a_last)))
    else $error("held character lost while stalled");

endmodule

FILE: design/b64d_serial.sv
module b64d_serial
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       bundle_valid,
  input  bundle_t    bundle,
  output logic       load_ok,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] data_byte
  output logic [2:0] m_tuser,   // [0] byte_valid, [2:1] status
  output logic       m_tlast    // end_of_message
);

  logic       busy, busy_next;
  logic [1:0] idx, idx_next;
  bundle_t    bnd, bnd_next;

  logic       last_idx;
  logic       m_fire;
  logic       load;

  assign last_idx = (idx == bnd.count - 2'd1);
  assign m_fire   = busy && m_tready;
  assign load_ok  = !busy || (m_tready && last_idx);
  assign load     = bundle_valid && load_ok;

  always_comb begin
    busy_next = busy;
    idx_next  = idx;
    bnd_next  = bnd;
    if (m_fire) begin
      if (last_idx) begin
        busy_next = 1'b0;
        idx_next  = '0;
      end else begin
        idx_next = idx + 2'd1;
      end
    end
    if (load) begin
      busy_next = 1'b1;
      idx_next  = '0;
      bnd_next  = bundle;
    end
  end

  always_comb begin
    case (idx)
      2'd0:    m_tdata = bnd.bytes[23:16];
      2'd1:    m_tdata = bnd.bytes[15:8];
      2'd2:    m_tdata = bnd.bytes[7:0];
      default: m_tdata = 8'd0;
    endcase
  end

  assign m_tvalid = busy;
  assign m_tuser  = {bnd.status, bnd.is_data};
  assign m_tlast  = bnd.eom && last_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      busy <= busy_next;
      idx  <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    bnd <= bnd_next;
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (bnd.count != 2'd0 && idx < bnd.count))
    else $error("word index outside loaded bundle");

  a_marker_single: assert property (@(posedge clk) disable iff (rst)
    (busy && !bnd.is_data) |-> (bnd.count == 2'd1 && bnd.bytes == 24'd0))
    else $error("marker bundle carries data");

endmodule
